// ===== sv/rtt_pkg.sv =====
`timescale 1ns / 1ps

package rtt_pkg;

  // Default table size and time width
  localparam int unsigned SLOTS_DEF     = 16;
  localparam int unsigned TIME_BITS_DEF = 32;

  // Stream word widths
  localparam int unsigned IN_TDATA_W  = 72;  // period_us, periodic, elapsed_us, zero fill
  localparam int unsigned OUT_TDATA_W = 8;   // handle, zero fill
  localparam int unsigned HANDLE_W    = 4;
  localparam int unsigned KIND_W      = 2;

  // Input action codes
  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_ELAPSE = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADDED   = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_EXPIRED = 2'd2,
    KIND_NONE    = 2'd3
  } rtt_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SUB,
    ST_NONE,
    ST_PICK,
    ST_EMIT,
    ST_RELOAD
  } rtt_state_e;

endpackage

// ===== sv/relative_timer_table_top.sv =====
`timescale 1ns / 1ps

// Relative timer table: SLOTS software timers kept as signed remaining times in microseconds.
//
// Input stream (s_axis): tuser selects the action (add a timer or report elapsed time),
// tdata carries period_us, periodic and elapsed_us. Output stream (m_axis): tuser is the
// result kind, tdata the slot handle, tlast marks the final word for one input word.
//
// The block takes one input word at a time; s_axis_tready_o is high only while the
// sequencer is idle. Remaining times, periods and periodic flags live in one memory with
// a single registered read port, and every scanning pass walks it one slot per cycle.
//   add:      a scan of the live flags for the lowest free slot, then the accept.
//   elapse:   a pass to subtract, then for each expired timer a pass to find the most
//             overdue one and a step to emit it, then a pass to reload periodic timers
//             and free one-shot ones; when nothing expired, a single none result and
//             no reload pass.
// A result sits in an output register, so the next input word is taken while the last
// result of the previous one still waits. If the receiver stalls, the sequencer holds
// before loading the next result and resumes when the output register frees up.
// Reset: all slots free, output empty, sequencer idle; timer memory contents are not
// cleared, since a slot's read data is only used once it has been written by an add.
module relative_timer_table_top
  import rtt_pkg::*;
#(
  parameter int unsigned SLOTS     = SLOTS_DEF,
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [31:0] period_us, [32] periodic, [64:33] elapsed_us, [71:65] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [0] action
  input  logic                   s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [3:0] handle, [7:4] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // [1:0] kind
  output logic [KIND_W-1:0]      m_axis_tuser_o,
  output logic                   m_axis_tlast_o
);

  localparam int unsigned IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW   = $clog2(SLOTS + 1);
  localparam int unsigned RW   = TIME_BITS + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  // Largest time value that fits, seen as a 32-bit input
  localparam logic [31:0] TOP32 = (TIME_BITS >= 32) ? 32'hFFFF_FFFF
                                                    : 32'((64'd1 << TIME_BITS) - 64'd1);

  // Control state
  rtt_state_e            state_q, state_d;
  logic [SLOTS-1:0]      live_q, live_d;
  logic [SLOTS-1:0]      pend_q, pend_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [IW-1:0]         scan_idx_q, scan_idx_d;
  logic                  issue_q, issue_d;
  logic [IW-1:0]         rd_idx_q, rd_idx_d;
  logic                  rd_vld_q, rd_vld_d;
  logic                  best_vld_q, best_vld_d;
  logic                  out_vld_q, out_vld_d;

  // Payload registers
  logic                  act_q, act_d;
  logic [TIME_BITS-1:0]  per_in_q, per_in_d;
  logic                  rep_in_q, rep_in_d;
  logic [TIME_BITS-1:0]  elap_q, elap_d;
  logic [IW-1:0]         best_q, best_d;
  logic signed [RW-1:0]  best_rem_q, best_rem_d;
  rtt_kind_e             out_kind_q, out_kind_d;
  logic [HANDLE_W-1:0]   out_handle_q, out_handle_d;
  logic                  out_last_q, out_last_d;

  // Slot memory and its registered read data
  logic signed [RW-1:0]  rem_mem [SLOTS];
  logic [TIME_BITS-1:0]  per_mem [SLOTS];
  logic                  rep_mem [SLOTS];
  logic signed [RW-1:0]  rd_rem_q;
  logic [TIME_BITS-1:0]  rd_per_q;
  logic                  rd_rep_q;

  logic                  rem_we, cfg_we;
  logic [IW-1:0]         mem_wa;
  logic signed [RW-1:0]  rem_wd;

  logic                  in_acc;
  logic                  out_free;
  logic                  scan_end;
  logic                  rd_expired;
  logic signed [RW-1:0]  diff;
  logic [31:0]           per_clamp, elap_clamp;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_vld_q || m_axis_tready_i;
  assign scan_end = rd_vld_q && (rd_idx_q == LAST_IDX);

  // Saturate wide inputs to the time range
  assign per_clamp  = (s_axis_tdata_i[31:0] > TOP32) ? TOP32 : s_axis_tdata_i[31:0];
  assign elap_clamp = (s_axis_tdata_i[64:33] > TOP32) ? TOP32 : s_axis_tdata_i[64:33];

  // The subtractor and the expiry test on the read slot
  assign diff       = rd_rem_q - $signed({1'b0, elap_q});
  assign rd_expired = rd_rem_q[RW-1] || (rd_rem_q == '0);

  always_comb begin
    state_d      = state_q;
    live_d       = live_q;
    pend_d       = pend_q;
    cnt_d        = cnt_q;
    scan_idx_d   = scan_idx_q;
    issue_d      = issue_q;
    rd_idx_d     = rd_idx_q;
    rd_vld_d     = 1'b0;
    best_vld_d   = best_vld_q;
    best_d       = best_q;
    best_rem_d   = best_rem_q;
    act_d        = act_q;
    per_in_d     = per_in_q;
    rep_in_d     = rep_in_q;
    elap_d       = elap_q;
    out_kind_d   = out_kind_q;
    out_handle_d = out_handle_q;
    out_last_d   = out_last_q;
    out_vld_d    = out_vld_q && !m_axis_tready_i;
    rem_we       = 1'b0;
    cfg_we       = 1'b0;
    mem_wa       = rd_idx_q;
    rem_wd       = diff;

    // Walk the slot memory one address per cycle in the scanning passes
    if ((state_q == ST_SUB || state_q == ST_PICK || state_q == ST_RELOAD) && issue_q) begin
      rd_vld_d = 1'b1;
      rd_idx_d = scan_idx_q;
      if (scan_idx_q == LAST_IDX) begin
        issue_d = 1'b0;
      end else begin
        scan_idx_d = scan_idx_q + 1'b1;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          act_d      = s_axis_tuser_i;
          per_in_d   = TIME_BITS'(per_clamp);
          rep_in_d   = s_axis_tdata_i[32];
          elap_d     = TIME_BITS'(elap_clamp);
          scan_idx_d = '0;
          issue_d    = 1'b1;
          cnt_d      = '0;
          pend_d     = '0;
          state_d    = (s_axis_tuser_i == ACT_ADD) ? ST_ADD : ST_SUB;
        end
      end

      ST_ADD: begin
        // Lowest free slot, one slot a cycle; once found, waits while the output is busy
        if (!live_q[scan_idx_q]) begin
          if (out_free) begin
            mem_wa       = scan_idx_q;
            rem_wd       = $signed({1'b0, per_in_q});
            rem_we       = 1'b1;
            cfg_we       = 1'b1;
            live_d[scan_idx_q] = 1'b1;
            out_vld_d    = 1'b1;
            out_kind_d   = KIND_ADDED;
            out_handle_d = HANDLE_W'(scan_idx_q);
            out_last_d   = 1'b1;
            state_d      = ST_IDLE;
          end
        end else if (scan_idx_q == LAST_IDX) begin
          if (out_free) begin
            out_vld_d    = 1'b1;
            out_kind_d   = KIND_FULL;
            out_handle_d = '0;
            out_last_d   = 1'b1;
            state_d      = ST_IDLE;
          end
        end else begin
          scan_idx_d = scan_idx_q + 1'b1;
        end
      end

      ST_SUB: begin
        // Subtract the elapsed time from each live slot and mark the expired ones
        if (rd_vld_q && live_q[rd_idx_q]) begin
          rem_we = 1'b1;
          if (diff[RW-1] || (diff == '0)) begin
            pend_d[rd_idx_q] = 1'b1;
            cnt_d            = cnt_q + 1'b1;
          end
        end
        if (scan_end) begin
          scan_idx_d = '0;
          issue_d    = 1'b1;
          best_vld_d = 1'b0;
          state_d    = (cnt_d == '0) ? ST_NONE : ST_PICK;
        end
      end

      ST_NONE: begin
        if (out_free) begin
          out_vld_d    = 1'b1;
          out_kind_d   = KIND_NONE;
          out_handle_d = '0;
          out_last_d   = 1'b1;
          state_d      = ST_IDLE;
        end
      end

      ST_PICK: begin
        // Keep the most overdue pending slot; strict compare leaves ties on the lower slot
        if (rd_vld_q && pend_q[rd_idx_q] && (!best_vld_q || (rd_rem_q < best_rem_q))) begin
          best_vld_d = 1'b1;
          best_d     = rd_idx_q;
          best_rem_d = rd_rem_q;
        end
        if (scan_end) begin
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_vld_d      = 1'b1;
          out_kind_d     = KIND_EXPIRED;
          out_handle_d   = HANDLE_W'(best_q);
          out_last_d     = (cnt_q == CW'(1));
          pend_d[best_q] = 1'b0;
          cnt_d          = cnt_q - 1'b1;
          scan_idx_d     = '0;
          issue_d        = 1'b1;
          best_vld_d     = 1'b0;
          state_d        = (cnt_q == CW'(1)) ? ST_RELOAD : ST_PICK;
        end
      end

      ST_RELOAD: begin
        // Rearm periodic timers, free one-shot ones
        if (rd_vld_q && live_q[rd_idx_q] && rd_expired) begin
          if (rd_rep_q) begin
            rem_we = 1'b1;
            rem_wd = $signed({1'b0, rd_per_q});
          end else begin
            live_d[rd_idx_q] = 1'b0;
          end
        end
        if (scan_end) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      live_q     <= '0;
      pend_q     <= '0;
      cnt_q      <= '0;
      scan_idx_q <= '0;
      issue_q    <= 1'b0;
      rd_idx_q   <= '0;
      rd_vld_q   <= 1'b0;
      best_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      live_q     <= live_d;
      pend_q     <= pend_d;
      cnt_q      <= cnt_d;
      scan_idx_q <= scan_idx_d;
      issue_q    <= issue_d;
      rd_idx_q   <= rd_idx_d;
      rd_vld_q   <= rd_vld_d;
      best_vld_q <= best_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    per_in_q     <= per_in_d;
    rep_in_q     <= rep_in_d;
    elap_q       <= elap_d;
    best_q       <= best_d;
    best_rem_q   <= best_rem_d;
    out_kind_q   <= out_kind_d;
    out_handle_q <= out_handle_d;
    out_last_q   <= out_last_d;
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (rem_we) begin
      rem_mem[mem_wa] <= rem_wd;
    end
    if (cfg_we) begin
      per_mem[mem_wa] <= per_in_q;
      rep_mem[mem_wa] <= rep_in_q;
    end
    rd_rem_q <= rem_mem[scan_idx_q];
    rd_per_q <= per_mem[scan_idx_q];
    rd_rep_q <= rep_mem[scan_idx_q];
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(out_handle_q);
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef ASSERT_OFF
  // Pending count tracks the pending flags while expired timers are handed out
  a_cnt_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PICK || state_q == ST_EMIT) |-> (cnt_q == $countones(pend_q)))
    else $error("pending count out of step with pending flags");

  // The slot about to be emitted is a pending, live timer
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (best_vld_q && pend_q[best_q] && live_q[best_q]))
    else $error("emit without a pending live slot");

  // A granted add leaves its slot live
  a_add_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD && cfg_we) |=> live_q[$past(scan_idx_q)])
    else $error("added slot not live");

  // Only expired results may be followed by more words of the same input
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != KIND_EXPIRED)) |-> m_axis_tlast_o)
    else $error("single result without last marker");
`endif

endmodule
